/* hdl/sprite_quad_vertex_gen_core_defines.svh */
// Assertion macros used by the checker file.
`ifndef SPRITE_QUAD_VERTEX_GEN_CORE_DEFINES_SVH
`define SPRITE_QUAD_VERTEX_GEN_CORE_DEFINES_SVH

// Checked property, ignored while reset is asserted.
`define SQVG_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) expr) else $error(msg);

// Checked property, evaluated at every edge including reset.
`define SQVG_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) expr) else $error(msg);

`endif

/* hdl/sqvg_pkg.sv */
package sqvg_pkg;

  localparam int BATCH_SLOTS = 512;
  localparam int SLOT_W      = 9;
  localparam logic [SLOT_W-1:0] SLOT_MASK = SLOT_W'(BATCH_SLOTS - 1);

  typedef struct packed {
    logic [8:0]         slot_index;
    logic               update_pending;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] size_x;
    logic signed [31:0] size_y;
    logic [15:0]        angle;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
  } sqvg_in_t;

  typedef struct packed {
    logic [10:0]        vertex_index;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic [15:0]        red_norm;
    logic [15:0]        green_norm;
    logic [15:0]        blue_norm;
    logic [15:0]        alpha_norm;
    logic               tex_u;
    logic               tex_v;
    logic               last_vertex;
  } sqvg_out_t;

  // Quarter-wave sine samples, sin(k*pi/32) in unsigned Q1.16 for k = 0..16.
  function automatic logic [16:0] sqvg_sine_lut(input logic [4:0] idx);
    logic [16:0] val;
    unique case (idx)
      5'd0:    val = 17'd0;
      5'd1:    val = 17'd6424;
      5'd2:    val = 17'd12785;
      5'd3:    val = 17'd19024;
      5'd4:    val = 17'd25079;
      5'd5:    val = 17'd30893;
      5'd6:    val = 17'd36410;
      5'd7:    val = 17'd41576;
      5'd8:    val = 17'd46341;
      5'd9:    val = 17'd50660;
      5'd10:   val = 17'd54491;
      5'd11:   val = 17'd57798;
      5'd12:   val = 17'd60547;
      5'd13:   val = 17'd62714;
      5'd14:   val = 17'd64277;
      5'd15:   val = 17'd65220;
      5'd16:   val = 17'd65536;
      default: val = 17'd0;
    endcase
    return val;
  endfunction

endpackage

/* hdl/sprite_quad_vertex_gen_core.sv */
// Channel  Direction  Payload     Handshake
// in_      input      sqvg_in_t   in_valid / in_ready
// out_     output     sqvg_out_t  out_valid / out_ready
//
// A sprite with its pending flag set yields four vertex beats, one per cycle while
// out_ready is high; sprites with the flag clear are taken and dropped. From input
// beat to first vertex the sprite passes the input register, the sine and cosine
// register and the vertex result register.
// The next sprite is taken while the current one is still emitting vertices.
// Reset is synchronous and clears only the valid flags and the corner count.
module sprite_quad_vertex_gen_core
  import sqvg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  sqvg_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output sqvg_out_t out_data
);

  function automatic logic [16:0] quarter_sine(input logic [14:0] p);
    logic [4:0]  i;
    logic [9:0]  f;
    logic [16:0] t0;
    logic [16:0] t1;
    logic [12:0] d;
    logic [22:0] prod;
    i  = p[14:10];
    f  = p[9:0];
    t0 = sqvg_sine_lut(i);
    t1 = sqvg_sine_lut(5'(i + 5'd1));
    d  = 13'(t1 - t0);
    prod = {10'd0, d} * {13'd0, f};
    if (i[4]) begin
      return t0;
    end
    return 17'(t0 + {4'd0, prod[22:10]});
  endfunction

  function automatic logic signed [17:0] full_sine(input logic [15:0] a);
    logic [14:0] ph;
    logic [16:0] v;
    ph = a[14] ? 15'(15'd16384 - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
    v  = quarter_sine(ph);
    return a[15] ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction

  // Input register.
  logic     s1_valid_r, s1_valid_nxt;
  sqvg_in_t s1_data_r;

  // Sine and cosine register, with the corner being emitted.
  logic               s2_valid_r, s2_valid_nxt;
  logic [1:0]         corner_r, corner_nxt;
  logic signed [17:0] sin_r, cos_r;
  sqvg_in_t           s2_data_r;

  // Result register.
  logic      out_valid_r, out_valid_nxt;
  sqvg_out_t out_data_r, out_data_nxt;

  logic in_fire, out_load, s2_free, s1_take;

  logic               cx, cy;
  logic signed [18:0] c_t, s_t, rx2, ry2;
  logic signed [50:0] prod_x, prod_y;
  logic [SLOT_W-1:0]  slot_mod;

  assign in_fire  = in_valid && in_ready;
  assign out_load = s2_valid_r && (!out_valid_r || out_ready);
  assign s2_free  = !s2_valid_r || (out_load && (corner_r == 2'd3));
  assign s1_take  = s1_valid_r && s2_free;
  assign in_ready = !s1_valid_r || s2_free;

  assign cx  = corner_r[0] ^ corner_r[1];
  assign cy  = corner_r[1];
  assign c_t = 19'(cos_r);
  assign s_t = 19'(sin_r);
  assign rx2 = (cx ? c_t : -c_t) - (cy ? s_t : -s_t);
  assign ry2 = (cx ? s_t : -s_t) + (cy ? c_t : -c_t);
  assign prod_x = 51'(rx2) * 51'(s2_data_r.size_x);
  assign prod_y = 51'(ry2) * 51'(s2_data_r.size_y);
  assign slot_mod = s2_data_r.slot_index & SLOT_MASK;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = in_data.update_pending;
    end else if (s1_take) begin
      s1_valid_nxt = 1'b0;
    end

    s2_valid_nxt = s2_valid_r;
    corner_nxt   = corner_r;
    if (s1_take) begin
      s2_valid_nxt = 1'b1;
      corner_nxt   = 2'd0;
    end else if (out_load) begin
      corner_nxt = 2'(corner_r + 2'd1);
      if (corner_r == 2'd3) begin
        s2_valid_nxt = 1'b0;
      end
    end

    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    out_data_nxt.vertex_index = {slot_mod, corner_r};
    out_data_nxt.vertex_x     = s2_data_r.pos_x + prod_x[48:17];
    out_data_nxt.vertex_y     = s2_data_r.pos_y + prod_y[48:17];
    out_data_nxt.red_norm     = {s2_data_r.red, s2_data_r.red};
    out_data_nxt.green_norm   = {s2_data_r.green, s2_data_r.green};
    out_data_nxt.blue_norm    = {s2_data_r.blue, s2_data_r.blue};
    out_data_nxt.alpha_norm   = {s2_data_r.alpha, s2_data_r.alpha};
    out_data_nxt.tex_u        = cx;
    out_data_nxt.tex_v        = cy;
    out_data_nxt.last_vertex  = (corner_r == 2'd3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      corner_r    <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      corner_r    <= corner_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_data;
    end
    if (s1_take) begin
      s2_data_r <= s1_data_r;
      sin_r     <= full_sine(s1_data_r.angle);
      cos_r     <= full_sine(16'(s1_data_r.angle + 16'd16384));
    end
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hdl/sqvg_checker.sv */
`include "sprite_quad_vertex_gen_core_defines.svh"

module sqvg_checker
  import sqvg_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input sqvg_out_t out_data
);

  `SQVG_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled vertex beat changed")
  `SQVG_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "vertex beat shown after reset")
  `SQVG_ASSERT(a_corner_fields, out_valid |-> (out_data.last_vertex == (out_data.vertex_index[1:0] == 2'd3)) && (out_data.tex_v == out_data.vertex_index[1]) && (out_data.tex_u == (out_data.vertex_index[1] ^ out_data.vertex_index[0])), "corner fields disagree with vertex index")
  `SQVG_ASSERT(a_quad_follows, out_valid && out_ready && !out_data.last_vertex |=> out_valid && (out_data.vertex_index == 11'($past(out_data.vertex_index) + 11'd1)) && (out_data.alpha_norm == $past(out_data.alpha_norm)) && (out_data.red_norm == $past(out_data.red_norm)), "quad not continued on the next cycle")

endmodule

bind sprite_quad_vertex_gen_core sqvg_checker u_sqvg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import sqvg_pkg::*;

  class quad_tracker;
    sqvg_out_t   vertex_queue[$];
    int          errors = 0;
    int unsigned wave[17] = '{0, 6424, 12785, 19024, 25079, 30893, 36410, 41576, 46341,
                              50660, 54491, 57798, 60547, 62714, 64277, 65220, 65536};

    function longint quarter_wave(int unsigned p);
      int unsigned i;
      int unsigned f;
      i = p >> 10;
      f = p & 1023;
      if (i >= 16) return longint'(wave[16]);
      return longint'(wave[i] + (((wave[i+1] - wave[i]) * f) >> 10));
    endfunction

    function longint turn_sine(int unsigned a);
      int unsigned q;
      int unsigned p;
      longint      v;
      q = (a >> 14) & 3;
      p = a & 16383;
      v = q[0] ? quarter_wave(16384 - p) : quarter_wave(p);
      return q[1] ? -v : v;
    endfunction

    function void take_sprite(sqvg_in_t s);
      longint    sn, cs, sx, sy, rx2, ry2;
      bit        cx, cy;
      sqvg_out_t v;
      if (!s.update_pending) return;
      sn = turn_sine(int'(s.angle));
      cs = turn_sine((int'(s.angle) + 16384) & 65535);
      for (int k = 0; k < 4; k++) begin
        cx = (k == 1) || (k == 2);
        cy = (k >= 2);
        sx = cx ? 1 : -1;
        sy = cy ? 1 : -1;
        rx2 = sx * cs - sy * sn;
        ry2 = sx * sn + sy * cs;
        v.vertex_index = 11'(s.slot_index) * 11'd4 + 11'(k);
        v.vertex_x     = 32'(longint'(s.pos_x) + ((rx2 * longint'(s.size_x)) >>> 17));
        v.vertex_y     = 32'(longint'(s.pos_y) + ((ry2 * longint'(s.size_y)) >>> 17));
        v.red_norm     = {s.red, s.red};
        v.green_norm   = {s.green, s.green};
        v.blue_norm    = {s.blue, s.blue};
        v.alpha_norm   = {s.alpha, s.alpha};
        v.tex_u        = cx;
        v.tex_v        = cy;
        v.last_vertex  = (k == 3);
        vertex_queue = {vertex_queue, v};
      end
    endfunction

    function void report(string field, logic [63:0] e, logic [63:0] a);
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, e, a);
      errors++;
    endfunction

    function void match_vertex(sqvg_out_t got);
      sqvg_out_t e;
      if (vertex_queue.size() == 0) begin
        $display("%0t ns: unexpected vertex, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      e = vertex_queue.pop_front();
      if (got.vertex_index !== e.vertex_index) report("vertex_index", e.vertex_index,
                                                       got.vertex_index);
      if (got.vertex_x !== e.vertex_x) report("vertex_x", e.vertex_x, got.vertex_x);
      if (got.vertex_y !== e.vertex_y) report("vertex_y", e.vertex_y, got.vertex_y);
      if (got.red_norm !== e.red_norm) report("red_norm", e.red_norm, got.red_norm);
      if (got.green_norm !== e.green_norm) report("green_norm", e.green_norm, got.green_norm);
      if (got.blue_norm !== e.blue_norm) report("blue_norm", e.blue_norm, got.blue_norm);
      if (got.alpha_norm !== e.alpha_norm) report("alpha_norm", e.alpha_norm, got.alpha_norm);
      if (got.tex_u !== e.tex_u) report("tex_u", e.tex_u, got.tex_u);
      if (got.tex_v !== e.tex_v) report("tex_v", e.tex_v, got.tex_v);
      if (got.last_vertex !== e.last_vertex) report("last_vertex", e.last_vertex,
                                                     got.last_vertex);
    endfunction

    function int outstanding();
      return vertex_queue.size();
    endfunction
  endclass

  localparam int HOLD_CYCLES   = 160;
  localparam int RANDOM_SPRITES = 270;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  sqvg_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  sqvg_out_t out_data;

  quad_tracker tracker = new();
  int          send_gap = 31;
  int          recv_gap = 31;
  bit          hold_req = 1'b0;
  sqvg_in_t    directed[$];

  sprite_quad_vertex_gen_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) tracker.take_sprite(in_data);
    if (rst_n && out_valid && out_ready) tracker.match_vertex(out_data);
  end

  // The receiver either stalls at random or, on request, holds off for a fixed stretch.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && rst_n) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_gap);
      end
    end
  end

  function automatic sqvg_in_t make_sprite(logic [8:0] slot, logic pend, logic [31:0] px,
                                           logic [31:0] py, logic [31:0] szx,
                                           logic [31:0] szy, logic [15:0] ang,
                                           logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                           logic [7:0] a);
    sqvg_in_t s;
    s.slot_index     = slot;
    s.update_pending = pend;
    s.pos_x          = px;
    s.pos_y          = py;
    s.size_x         = szx;
    s.size_y         = szy;
    s.angle          = ang;
    s.red            = r;
    s.green          = g;
    s.blue           = b;
    s.alpha          = a;
    return s;
  endfunction

  function automatic void add_directed(sqvg_in_t s);
    directed = {directed, s};
  endfunction

  function automatic logic [31:0] random_size();
    logic [31:0] mag;
    if ($urandom_range(0, 3) == 0) return $urandom;
    mag = $urandom_range(0, 32'h0040_0000);
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  function automatic sqvg_in_t random_sprite();
    logic [31:0] px, py;
    px = $urandom_range(0, 1) ? $urandom : 32'($signed(24'($urandom)));
    py = $urandom_range(0, 1) ? $urandom : 32'($signed(24'($urandom)));
    return make_sprite(9'($urandom), $urandom_range(0, 99) < 85, px, py, random_size(),
                       random_size(), 16'($urandom), 8'($urandom), 8'($urandom),
                       8'($urandom), 8'($urandom));
  endfunction

  task automatic offer_sprite(input sqvg_in_t s);
    while ($urandom_range(0, 99) < send_gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_empty(input int limit);
    int n;
    n = 0;
    @(posedge clk);
    while (tracker.outstanding() != 0 && n < limit) begin
      @(posedge clk);
      n++;
    end
    repeat (10) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_directed(make_sprite(9'd0, 1'b1, 32'd0, 32'd0, 32'h0001_0000, 32'h0001_0000,
                             16'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    add_directed(make_sprite(9'd511, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                             32'h8000_0000, 16'd16384, 8'd255, 8'd255, 8'd255, 8'd255));
    add_directed(make_sprite(9'd511, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                             32'hFFFF_FFFF, 16'hFFFF, 8'd255, 8'd255, 8'd255, 8'd255));
    add_directed(make_sprite(9'd1, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                             32'h7FFF_FFFF, 16'd32768, 8'd1, 8'd128, 8'd254, 8'd127));
    add_directed(make_sprite(9'd2, 1'b1, 32'h0010_0000, 32'hFFF0_0000, 32'h0020_0000,
                             32'h0008_0000, 16'd49152, 8'h55, 8'hAA, 8'h0F, 8'hF0));
    add_directed(make_sprite(9'd3, 1'b1, 32'h0000_0001, 32'hFFFF_FFFF, 32'd3, 32'd5,
                             16'd65535, 8'd10, 8'd20, 8'd30, 8'd40));
    add_directed(make_sprite(9'd4, 1'b1, 32'd0, 32'd0, 32'hFFFF_FFFD, 32'hFFFF_FFF9,
                             16'd1, 8'd0, 8'd255, 8'd0, 8'd255));
    add_directed(make_sprite(9'd5, 1'b1, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                             32'hFFFD_0000, 16'd16383, 8'd255, 8'd0, 8'd255, 8'd0));
    add_directed(make_sprite(9'd6, 1'b1, 32'h1234_5678, 32'h8765_4321, 32'h0000_8001,
                             32'h0001_7FFF, 16'd16385, 8'd77, 8'd88, 8'd99, 8'd11));
    add_directed(make_sprite(9'd7, 1'b1, 32'd0, 32'd0, 32'h0100_0000, 32'h0100_0000,
                             16'd8192, 8'd200, 8'd100, 8'd50, 8'd25));
    add_directed(make_sprite(9'd8, 1'b1, 32'd0, 32'd0, 32'h0100_0000, 32'hFF00_0000,
                             16'd1023, 8'd3, 8'd6, 8'd9, 8'd12));
    add_directed(make_sprite(9'd9, 1'b1, 32'd0, 32'd0, 32'h0001_0001, 32'h0001_0001,
                             16'd1024, 8'd4, 8'd8, 8'd16, 8'd32));
    add_directed(make_sprite(9'd10, 1'b1, 32'hFFFF_0000, 32'h0001_0000, 32'd7, 32'd11,
                             16'd32767, 8'd64, 8'd128, 8'd192, 8'd1));
    add_directed(make_sprite(9'd256, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0,
                             8'd0, 8'd0, 8'd0, 8'd0));
    add_directed(make_sprite(9'd255, 1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                             32'h8000_0000, 16'd0, 8'd255, 8'd254, 8'd1, 8'd0));
    add_directed(make_sprite(9'd256, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                             32'h7FFF_FFFF, 16'd40000, 8'd90, 8'd91, 8'd92, 8'd93));
    add_directed(make_sprite(9'd170, 1'b1, 32'd0, 32'd0, 32'd0, 32'd0, 16'd57344,
                             8'd17, 8'd34, 8'd51, 8'd68));
    add_directed(make_sprite(9'd341, 1'b1, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'hFFFF_FFFF,
                             16'd24576, 8'd5, 8'd6, 8'd7, 8'd8));
    foreach (directed[i]) offer_sprite(directed[i]);

    for (int n = 0; n < RANDOM_SPRITES; n++) begin
      if (n == 90) begin
        hold_req = 1'b1;
      end
      if (n == 150) begin
        in_valid <= 1'b0;
        wait_empty(20000);
        send_gap = 0;
        recv_gap = 0;
      end
      if (n == 220) begin
        send_gap = 31;
        recv_gap = 31;
      end
      offer_sprite(random_sprite());
    end
    in_valid <= 1'b0;

    wait_empty(20000);
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("TB_OK");
    end else begin
      if (tracker.outstanding() != 0) begin
        $display("%0t ns: %0d vertices never arrived", $time, tracker.outstanding());
      end
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
